// ===== rtl/core/tcrg_pkg.sv =====
// ----------------------------------------------------------------------------
// tcrg_pkg
// Shared types and constants for the tilt change report gate.
// ----------------------------------------------------------------------------
package tcrg_pkg;

    localparam int AXIS_W  = 16;
    localparam int REQ_W   = 3;
    localparam int THR_W   = 50;
    localparam int BURST_W = 3;
    localparam int SKIP_W  = 6;
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 64;

    // cross term, shifted magnitude, multiplier operand, kept product, sum
    localparam int CROSS_W = 33;
    localparam int MAG_W   = 24;
    localparam int OPND_W  = 25;
    localparam int PROD_W  = 48;
    localparam int SUM_W   = 48;

    localparam logic [THR_W-1:0]   THR_RESET       = THR_W'(958287526);
    localparam logic [BURST_W-1:0] BURST_CHG_RESET = BURST_W'(4);
    localparam logic [BURST_W-1:0] BURST_EN_RESET  = BURST_W'(5);
    localparam logic [SKIP_W-1:0]  MAX_SKIP_RESET  = SKIP_W'(50);

    localparam logic [1:0] LAST_AXIS = 2'd2;

    typedef enum logic [REQ_W-1:0] {
        REQ_SAMPLE     = 3'd0,
        REQ_CONNECT    = 3'd1,
        REQ_DISCONNECT = 3'd2,
        REQ_NOTIFY_ON  = 3'd3,
        REQ_NOTIFY_OFF = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_SUM,
        S_DECIDE
    } state_t;

    typedef enum logic [2:0] {
        SUB_MUL_A,
        SUB_MUL_B,
        SUB_DIFF,
        SUB_ABS,
        SUB_SQ
    } sub_t;

    typedef enum logic [1:0] {
        REG_CHANGE_THRESHOLD   = 2'd0,
        REG_BURST_AFTER_CHANGE = 2'd1,
        REG_BURST_ON_ENABLE    = 2'd2,
        REG_MAX_SKIPPED        = 2'd3
    } reg_idx_t;

endpackage

// ===== rtl/core/tcrg_if.sv =====
// ----------------------------------------------------------------------------
// tcrg_req_if / tcrg_rsp_if
// Valid/ready channels carrying requests into and results out of the gate.
// ----------------------------------------------------------------------------
interface tcrg_req_if;
    import tcrg_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic signed [AXIS_W-1:0] sample_x;
    logic signed [AXIS_W-1:0] sample_y;
    logic signed [AXIS_W-1:0] sample_z;

    modport source (output valid, req_type, sample_x, sample_y, sample_z, input ready);
    modport sink   (input valid, req_type, sample_x, sample_y, sample_z, output ready);
endinterface

interface tcrg_rsp_if;
    import tcrg_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     send_report;
    logic                     status;
    logic signed [AXIS_W-1:0] report_x;
    logic signed [AXIS_W-1:0] report_y;
    logic signed [AXIS_W-1:0] report_z;

    modport source (output valid, send_report, status, report_x, report_y, report_z,
                    input ready);
    modport sink   (input valid, send_report, status, report_x, report_y, report_z,
                    output ready);
endinterface

// ===== rtl/core/tilt_change_report_gate.sv =====
// ----------------------------------------------------------------------------
// tilt_change_report_gate
// Decides which accelerometer samples are reported, from the size of the
// cross product between each sample and the last reported vector.
//
//   channel | dir | beat
//   --------+-----+--------------------------------------------------------
//   req     | in  | req_type, sample_x/y/z
//   rsp     | out | send_report, status, report_x/y/z
//   apb     | in  | register writes and reads, 64-bit data, pready tied high
//
// A sample on an open link runs from accept to result through five steps
// of the one shared 25x25 multiplier per cross axis, then a sum and a decide.
// Events, unknown requests and samples on a closed link give their result
// in the cycle after accept. A result waiting on rsp holds the block in
// its decide step or keeps req.ready low. Reset is asynchronous, active low,
// and needs no clearing pass.
// ----------------------------------------------------------------------------
module tilt_change_report_gate (
    input  logic                           clk,
    input  logic                           rst_n,
    tcrg_req_if.sink                       req,
    tcrg_rsp_if.source                     rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tcrg_pkg::APB_AW-1:0]    paddr,
    input  logic [tcrg_pkg::APB_DW-1:0]    pwdata,
    output logic [tcrg_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);
    import tcrg_pkg::*;

    // configuration
    logic [THR_W-1:0]   change_threshold_reg;
    logic [BURST_W-1:0] burst_after_change_reg;
    logic [BURST_W-1:0] burst_on_enable_reg;
    logic [SKIP_W-1:0]  max_skipped_reg;

    // link and gate state
    logic                     connected_reg;
    logic                     notify_on_reg;
    logic [BURST_W-1:0]       burst_left_reg;
    logic [SKIP_W-1:0]        skip_count_reg;
    logic signed [AXIS_W-1:0] last_x_reg, last_y_reg, last_z_reg;

    // sequencer
    state_t     state_reg, state_next;
    sub_t       sub_reg, sub_next;
    logic [1:0] axis_reg, axis_next;

    // datapath
    logic signed [AXIS_W-1:0]  ux_reg, uy_reg, uz_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [CROSS_W-1:0] cross_reg;
    logic [MAG_W-1:0]          mag_reg;
    logic [SUM_W-1:0]          sum_reg;

    // result
    logic                     out_valid_reg, out_valid_next;
    logic                     send_reg, status_reg;
    logic signed [AXIS_W-1:0] rep_x_reg, rep_y_reg, rep_z_reg;

    logic                      acc_in, out_take, out_free, cfg_wr;
    logic                      link_ok, load_out, res_send, res_status;
    logic                      big_change, do_report;
    logic [BURST_W-1:0]        burst_eff;
    logic signed [OPND_W-1:0]  mul_a, mul_b;
    logic signed [2*OPND_W-1:0] mul_p;
    logic signed [OPND_W-1:0]  shifted, shifted_neg;
    reg_idx_t                  reg_idx;

    // ------------------------------------------------------------------
    // APB
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[4:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (reg_idx)
            REG_CHANGE_THRESHOLD:   prdata = APB_DW'(change_threshold_reg);
            REG_BURST_AFTER_CHANGE: prdata = APB_DW'(burst_after_change_reg);
            REG_BURST_ON_ENABLE:    prdata = APB_DW'(burst_on_enable_reg);
            REG_MAX_SKIPPED:        prdata = APB_DW'(max_skipped_reg);
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            change_threshold_reg   <= THR_RESET;
            burst_after_change_reg <= BURST_CHG_RESET;
            burst_on_enable_reg    <= BURST_EN_RESET;
            max_skipped_reg        <= MAX_SKIP_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_CHANGE_THRESHOLD:   change_threshold_reg   <= pwdata[THR_W-1:0];
                REG_BURST_AFTER_CHANGE: burst_after_change_reg <= pwdata[BURST_W-1:0];
                REG_BURST_ON_ENABLE:    burst_on_enable_reg    <= pwdata[BURST_W-1:0];
                REG_MAX_SKIPPED:        max_skipped_reg        <= pwdata[SKIP_W-1:0];
                default:                ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign acc_in    = req.valid && req.ready;
    assign out_take  = rsp.valid && rsp.ready;
    assign link_ok   = connected_reg && notify_on_reg;

    assign rsp.valid       = out_valid_reg;
    assign rsp.send_report = send_reg;
    assign rsp.status      = status_reg;
    assign rsp.report_x    = rep_x_reg;
    assign rsp.report_y    = rep_y_reg;
    assign rsp.report_z    = rep_z_reg;

    // ------------------------------------------------------------------
    // Shared multiplier: cross products per axis, then the square
    // ------------------------------------------------------------------
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (sub_reg)
            SUB_MUL_A:
            begin
                case (axis_reg)
                    2'd0:    begin mul_a = OPND_W'(uy_reg); mul_b = OPND_W'(last_z_reg); end
                    2'd1:    begin mul_a = OPND_W'(uz_reg); mul_b = OPND_W'(last_x_reg); end
                    default: begin mul_a = OPND_W'(ux_reg); mul_b = OPND_W'(last_y_reg); end
                endcase
            end
            SUB_MUL_B:
            begin
                case (axis_reg)
                    2'd0:    begin mul_a = OPND_W'(uz_reg); mul_b = OPND_W'(last_y_reg); end
                    2'd1:    begin mul_a = OPND_W'(last_z_reg); mul_b = OPND_W'(ux_reg); end
                    default: begin mul_a = OPND_W'(uy_reg); mul_b = OPND_W'(last_x_reg); end
                endcase
            end
            SUB_SQ:
            begin
                mul_a = $signed({1'b0, mag_reg});
                mul_b = $signed({1'b0, mag_reg});
            end
            default: ;
        endcase
    end

    assign mul_p       = mul_a * mul_b;
    // floor shift by 8, then magnitude
    assign shifted     = cross_reg[CROSS_W-1:8];
    assign shifted_neg = -shifted;

    // ------------------------------------------------------------------
    // Gate decision
    // ------------------------------------------------------------------
    assign big_change = {{(THR_W-SUM_W){1'b0}}, sum_reg} > change_threshold_reg;
    assign burst_eff  = big_change ? burst_after_change_reg : burst_left_reg;
    assign do_report  = big_change || (burst_eff != '0) || (skip_count_reg >= max_skipped_reg);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        sub_next   = sub_reg;
        axis_next  = axis_reg;
        load_out   = 1'b0;
        res_send   = 1'b0;
        res_status = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc_in)
                begin
                    if (req.req_type == REQ_SAMPLE && link_ok)
                    begin
                        state_next = S_CALC;
                        sub_next   = SUB_MUL_A;
                        axis_next  = 2'd0;
                    end
                    else
                    begin
                        load_out   = 1'b1;
                        res_status = (req.req_type == REQ_SAMPLE);
                    end
                end
            end
            S_CALC:
            begin
                unique case (sub_reg)
                    SUB_MUL_A: sub_next = SUB_MUL_B;
                    SUB_MUL_B: sub_next = SUB_DIFF;
                    SUB_DIFF:  sub_next = SUB_ABS;
                    SUB_ABS:   sub_next = SUB_SQ;
                    SUB_SQ:
                    begin
                        sub_next  = SUB_MUL_A;
                        axis_next = axis_reg + 2'd1;
                        if (axis_reg == LAST_AXIS)
                            state_next = S_SUM;
                    end
                    default:   sub_next = SUB_MUL_A;
                endcase
            end
            S_SUM:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    res_send   = do_report;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_take)
            out_valid_next = 1'b0;
    end

    // control and gate state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            sub_reg        <= SUB_MUL_A;
            axis_reg       <= 2'd0;
            out_valid_reg  <= 1'b0;
            connected_reg  <= 1'b0;
            notify_on_reg  <= 1'b0;
            burst_left_reg <= '0;
            skip_count_reg <= '0;
            last_x_reg     <= '0;
            last_y_reg     <= '0;
            last_z_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sub_reg       <= sub_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;

            if (state_reg == S_IDLE && acc_in)
            begin
                unique case (req.req_type)
                    REQ_CONNECT:    connected_reg <= 1'b1;
                    REQ_DISCONNECT: connected_reg <= 1'b0;
                    REQ_NOTIFY_ON:
                    begin
                        notify_on_reg  <= 1'b1;
                        burst_left_reg <= burst_on_enable_reg;
                        skip_count_reg <= '0;
                    end
                    REQ_NOTIFY_OFF: notify_on_reg <= 1'b0;
                    default:        ;
                endcase
            end

            if (state_reg == S_DECIDE && out_free)
            begin
                if (do_report)
                begin
                    burst_left_reg <= (burst_eff != '0) ? burst_eff - 1'b1 : '0;
                    skip_count_reg <= '0;
                    last_x_reg     <= ux_reg;
                    last_y_reg     <= uy_reg;
                    last_z_reg     <= uz_reg;
                end
                else
                begin
                    skip_count_reg <= skip_count_reg + 1'b1;
                end
            end
        end
    end

    // datapath and result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && acc_in)
        begin
            ux_reg   <= req.sample_x;
            uy_reg   <= req.sample_y;
            uz_reg   <= req.sample_z;
            prod_reg <= '0;
            sum_reg  <= '0;
        end

        if (state_reg == S_CALC)
        begin
            case (sub_reg)
                SUB_MUL_A:
                begin
                    // previous axis' square is folded in here
                    sum_reg  <= sum_reg + $unsigned(prod_reg);
                    prod_reg <= mul_p[PROD_W-1:0];
                end
                SUB_MUL_B:
                begin
                    cross_reg <= $signed(prod_reg[CROSS_W-1:0]);
                    prod_reg  <= mul_p[PROD_W-1:0];
                end
                SUB_DIFF:
                    cross_reg <= cross_reg - $signed(prod_reg[CROSS_W-1:0]);
                SUB_ABS:
                    mag_reg <= shifted[OPND_W-1] ? shifted_neg[MAG_W-1:0]
                                                 : shifted[MAG_W-1:0];
                SUB_SQ:
                    prod_reg <= mul_p[PROD_W-1:0];
                default: ;
            endcase
        end

        if (state_reg == S_SUM)
            sum_reg <= sum_reg + $unsigned(prod_reg);

        if (load_out)
        begin
            send_reg   <= res_send;
            status_reg <= res_status;
            rep_x_reg  <= res_send ? ux_reg : '0;
            rep_y_reg  <= res_send ? uy_reg : '0;
            rep_z_reg  <= res_send ? uz_reg : '0;
        end
    end

`ifndef NO_ASSERTIONS
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !req.ready)
        else $error("request taken while a sample is in flight");

    a_send_status_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.send_report && rsp.status))
        else $error("report and invalid status together");

    a_skip_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.send_report) |->
        (rsp.report_x == '0 && rsp.report_y == '0 && rsp.report_z == '0))
        else $error("skipped beat carries nonzero axes");

    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CALC) |-> (axis_reg <= LAST_AXIS))
        else $error("axis counter out of range");

    a_last_follows_report: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE && out_free && do_report) |=>
        (last_x_reg == $past(ux_reg) && last_y_reg == $past(uy_reg)
         && skip_count_reg == '0))
        else $error("reported sample not stored as last vector");
`endif

endmodule

// ===== tb/tcrg_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcrg_tb_pkg
// Report predictor and scoreboard for the tilt change report gate: keeps its
// own copy of the link state, burst and skip counters and the last reported
// vector, and checks each result beat against the oldest prediction.
// ----------------------------------------------------------------------------
package tcrg_tb_pkg;

    import tcrg_pkg::*;

    typedef struct {
        logic                     send;
        logic                     status;
        logic signed [AXIS_W-1:0] x;
        logic signed [AXIS_W-1:0] y;
        logic signed [AXIS_W-1:0] z;
    } gate_result_t;

    class tilt_report_scoreboard;
        logic [THR_W-1:0]         threshold;
        logic [BURST_W-1:0]       burst_chg;
        logic [BURST_W-1:0]       burst_en;
        logic [SKIP_W-1:0]        max_skip;
        logic signed [AXIS_W-1:0] last_x;
        logic signed [AXIS_W-1:0] last_y;
        logic signed [AXIS_W-1:0] last_z;
        logic [BURST_W-1:0]       burst_left;
        logic [SKIP_W-1:0]        skip_count;
        bit                       connected;
        bit                       notify_on;
        gate_result_t             pending_reports[$];
        int                       mismatches;

        function new();
            threshold  = THR_RESET;
            burst_chg  = BURST_CHG_RESET;
            burst_en   = BURST_EN_RESET;
            max_skip   = MAX_SKIP_RESET;
            last_x     = '0;
            last_y     = '0;
            last_z     = '0;
            burst_left = '0;
            skip_count = '0;
            connected  = 1'b0;
            notify_on  = 1'b0;
            mismatches = 0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [APB_DW-1:0] value);
            case (idx)
                REG_CHANGE_THRESHOLD:   threshold = value[THR_W-1:0];
                REG_BURST_AFTER_CHANGE: burst_chg = value[BURST_W-1:0];
                REG_BURST_ON_ENABLE:    burst_en  = value[BURST_W-1:0];
                REG_MAX_SKIPPED:        max_skip  = value[SKIP_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [APB_DW-1:0] reg_value(reg_idx_t idx);
            case (idx)
                REG_CHANGE_THRESHOLD:   return APB_DW'(threshold);
                REG_BURST_AFTER_CHANGE: return APB_DW'(burst_chg);
                REG_BURST_ON_ENABLE:    return APB_DW'(burst_en);
                default:                return APB_DW'(max_skip);
            endcase
        endfunction

        function int pending();
            return pending_reports.size();
        endfunction

        // floor(c / 256) squared; >>> on a longint floors negatives
        function longint unsigned shifted_square(longint c);
            longint q;
            q = c >>> 8;
            return longint'(q * q);
        endfunction

        function void note_request(logic [REQ_W-1:0] kind, logic signed [AXIS_W-1:0] x,
                                   logic signed [AXIS_W-1:0] y, logic signed [AXIS_W-1:0] z);
            gate_result_t     r;
            longint           cx;
            longint           cy;
            longint           cz;
            longint unsigned  sum;
            bit               big_change;

            r.send   = 1'b0;
            r.status = 1'b0;
            r.x      = '0;
            r.y      = '0;
            r.z      = '0;
            case (kind)
                REQ_CONNECT:    connected = 1'b1;
                REQ_DISCONNECT: connected = 1'b0;
                REQ_NOTIFY_ON:
                begin
                    notify_on  = 1'b1;
                    burst_left = burst_en;
                    skip_count = '0;
                end
                REQ_NOTIFY_OFF: notify_on = 1'b0;
                REQ_SAMPLE:
                begin
                    if (!connected || !notify_on)
                    begin
                        r.status = 1'b1;
                    end
                    else
                    begin
                        cx = longint'(y) * longint'(last_z) - longint'(z) * longint'(last_y);
                        cy = longint'(z) * longint'(last_x) - longint'(last_z) * longint'(x);
                        cz = longint'(x) * longint'(last_y) - longint'(y) * longint'(last_x);
                        sum = shifted_square(cx) + shifted_square(cy) + shifted_square(cz);
                        big_change = sum > 64'(threshold);
                        if (big_change)
                            burst_left = burst_chg;
                        if (burst_left == 0 && !big_change && skip_count < max_skip)
                        begin
                            skip_count = skip_count + 1'b1;
                        end
                        else
                        begin
                            if (burst_left != 0)
                                burst_left = burst_left - 1'b1;
                            skip_count = '0;
                            last_x = x;
                            last_y = y;
                            last_z = z;
                            r.send = 1'b1;
                            r.x    = x;
                            r.y    = y;
                            r.z    = z;
                        end
                    end
                end
                default: ;  // reserved request codes change no state but still give a result
            endcase
            pending_reports.push_back(r);
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_report(gate_result_t got);
            gate_result_t want;
            if (pending_reports.size() == 0)
            begin
                report("result beat with no prediction waiting");
            end
            else
            begin
                want = pending_reports.pop_front();
                if (got.send !== want.send)
                    report($sformatf("send_report got %b, want %b", got.send, want.send));
                if (got.status !== want.status)
                    report($sformatf("status got %b, want %b", got.status, want.status));
                if (got.x !== want.x)
                    report($sformatf("report_x got %0d, want %0d", got.x, want.x));
                if (got.y !== want.y)
                    report($sformatf("report_y got %0d, want %0d", got.y, want.y));
                if (got.z !== want.z)
                    report($sformatf("report_z got %0d, want %0d", got.z, want.z));
            end
        endtask
    endclass

endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives requests and register writes into the tilt change report gate,
// predicts every result beat and checks it, with random stalls on both
// channels, a long receiver hold-off and several register settings.
// ----------------------------------------------------------------------------
module tb_top;

    import tcrg_pkg::*;
    import tcrg_tb_pkg::*;

    localparam int REQ_LAST_CODE = (1 << REQ_W) - 1;
    localparam int LONG_HOLD     = 300;
    localparam int PHASE_ITEMS   = 225;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    bit calm;
    bit hold_due;

    tilt_report_scoreboard gate_sb;

    tcrg_req_if req_if ();
    tcrg_rsp_if rsp_if ();

    tilt_change_report_gate u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if),
        .rsp     (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [AXIS_W-1:0] extreme_axis();
        case ($urandom_range(0, 4))
            0:       return 16'sh8000;
            1:       return -16'sd1;
            2:       return 16'sd0;
            3:       return 16'sd1;
            default: return 16'sh7fff;
        endcase
    endfunction

    // one request beat; returns after acceptance and any random idle gap
    task automatic drive_request(input logic [REQ_W-1:0] kind,
                                 input logic signed [AXIS_W-1:0] x,
                                 input logic signed [AXIS_W-1:0] y,
                                 input logic signed [AXIS_W-1:0] z);
        int gap;
        req_if.valid    <= 1'b1;
        req_if.req_type <= kind;
        req_if.sample_x <= x;
        req_if.sample_y <= y;
        req_if.sample_z <= z;
        do
            @(posedge clk);
        while (!req_if.ready);
        gate_sb.note_request(kind, x, y, z);
        gap = pick_gap();
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        req_if.valid <= 1'b0;
        while (gate_sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_access(input bit wr, input reg_idx_t idx,
                              input logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_AW'({idx, 3'b000});
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_register(input reg_idx_t idx, input logic [APB_DW-1:0] value);
        logic [APB_DW-1:0] rdata;
        apb_access(1'b1, idx, value, rdata);
        gate_sb.write_reg(idx, value);
        apb_access(1'b0, idx, '0, rdata);
        if (rdata !== gate_sb.reg_value(idx))
            gate_sb.report($sformatf("register %s read %0h, want %0h",
                                     idx.name(), rdata, gate_sb.reg_value(idx)));
    endtask

    task automatic configure(input logic [APB_DW-1:0] thr, input int burst_chg,
                             input int burst_en, input int max_skip);
        set_register(REG_CHANGE_THRESHOLD, thr);
        set_register(REG_BURST_AFTER_CHANGE, APB_DW'(burst_chg));
        set_register(REG_BURST_ON_ENABLE, APB_DW'(burst_en));
        set_register(REG_MAX_SKIPPED, APB_DW'(max_skip));
    endtask

    // mostly vectors close to or parallel with the last report, so that
    // skips and forced reports are reached as well as large changes
    task automatic pick_sample(output logic signed [AXIS_W-1:0] sx,
                               output logic signed [AXIS_W-1:0] sy,
                               output logic signed [AXIS_W-1:0] sz);
        int mode;
        int span;
        int sh;
        mode = $urandom_range(0, 9);
        case (mode)
            0, 1, 2:
            begin
                sx = 16'($urandom);
                sy = 16'($urandom);
                sz = 16'($urandom);
            end
            3, 4, 5, 8, 9:
            begin
                span = (mode >= 8) ? 16 : (1 << $urandom_range(0, 12));
                sx = 16'(gate_sb.last_x + ($urandom_range(0, 2 * span) - span));
                sy = 16'(gate_sb.last_y + ($urandom_range(0, 2 * span) - span));
                sz = 16'(gate_sb.last_z + ($urandom_range(0, 2 * span) - span));
            end
            6:
            begin
                sh = $urandom_range(0, 3);
                sx = gate_sb.last_x >>> sh;
                sy = gate_sb.last_y >>> sh;
                sz = gate_sb.last_z >>> sh;
                if ($urandom_range(0, 1) == 1)
                begin
                    sx = -sx;
                    sy = -sy;
                    sz = -sz;
                end
            end
            default:
            begin
                sx = extreme_axis();
                sy = extreme_axis();
                sz = extreme_axis();
            end
        endcase
    endtask

    task automatic random_item();
        logic [REQ_W-1:0]         kind;
        logic signed [AXIS_W-1:0] sx;
        logic signed [AXIS_W-1:0] sy;
        logic signed [AXIS_W-1:0] sz;
        int                       roll;
        roll = $urandom_range(0, 99);
        if (gate_sb.connected && gate_sb.notify_on)
        begin
            if (roll < 90)
                kind = REQ_SAMPLE;
            else
                kind = REQ_W'($urandom_range(1, REQ_LAST_CODE));
        end
        else if (roll < 60)
            kind = gate_sb.connected ? REQ_NOTIFY_ON : REQ_CONNECT;
        else if (roll < 85)
            kind = REQ_SAMPLE;
        else
            kind = REQ_W'($urandom_range(1, REQ_LAST_CODE));

        if (kind == REQ_SAMPLE && gate_sb.connected && gate_sb.notify_on)
        begin
            pick_sample(sx, sy, sz);
        end
        else
        begin
            sx = 16'($urandom);
            sy = 16'($urandom);
            sz = 16'($urandom);
        end
        drive_request(kind, sx, sy, sz);
    endtask

    task automatic run_phase(input int count, input bit with_hold, input bit with_pause);
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (with_hold && i == 60)
                hold_due = 1'b1;
            if (with_pause && i == count / 2)
                drain_results();
            random_item();
        end
        calm = 1'b0;
        drain_results();
    endtask

    // result side: checks each beat, then decides ready for the next cycle
    initial
    begin
        int           stall_left;
        gate_result_t got;
        rsp_if.ready <= 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_if.valid && rsp_if.ready)
            begin
                got.send   = rsp_if.send_report;
                got.status = rsp_if.status;
                got.x      = rsp_if.report_x;
                got.y      = rsp_if.report_y;
                got.z      = rsp_if.report_z;
                gate_sb.check_report(got);
            end
            if (hold_due)
            begin
                hold_due   = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("** tilt_change_report_gate: FAILED **");
        $finish;
    end

    initial
    begin
        logic [APB_DW-1:0] thr;
        gate_sb  = new();
        calm     = 1'b0;
        hold_due = 1'b0;
        rst_n           <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        req_if.valid    <= 1'b0;
        req_if.req_type <= REQ_SAMPLE;
        req_if.sample_x <= '0;
        req_if.sample_y <= '0;
        req_if.sample_z <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: closed link, bursts from enable, axis extremes, events
        drive_request(REQ_SAMPLE, 16'sd0, 16'sd0, 16'sd0);
        drive_request(REQ_NOTIFY_ON, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        drive_request(REQ_SAMPLE, 16'sd1, 16'sd2, 16'sd3);
        drive_request(REQ_CONNECT, 16'sh8000, 16'sh8000, 16'sh8000);
        drive_request(REQ_SAMPLE, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        drive_request(REQ_SAMPLE, 16'sh8000, 16'sh8000, 16'sh8000);
        drive_request(REQ_SAMPLE, 16'sh7fff, 16'sh8000, 16'sd0);
        drive_request(REQ_SAMPLE, 16'sh8000, 16'sh7fff, -16'sd1);
        drive_request(REQ_SAMPLE, 16'sd0, 16'sd0, 16'sd0);
        drive_request(REQ_SAMPLE, -16'sd1, -16'sd1, -16'sd1);
        for (int k = int'(REQ_NOTIFY_OFF) + 1; k <= REQ_LAST_CODE; k++)
            drive_request(REQ_W'(k), 16'sh7fff, 16'sh8000, -16'sd1);
        drive_request(REQ_NOTIFY_OFF, 16'sd0, 16'sd0, 16'sd0);
        drive_request(REQ_SAMPLE, 16'sd100, 16'sd200, 16'sd300);
        drive_request(REQ_DISCONNECT, 16'sd0, 16'sd0, 16'sd0);
        drive_request(REQ_SAMPLE, 16'sd100, 16'sd200, 16'sd300);
        drive_request(REQ_CONNECT, 16'sd0, 16'sd0, 16'sd0);
        drive_request(REQ_NOTIFY_ON, 16'sd0, 16'sd0, 16'sd0);
        drive_request(REQ_SAMPLE, 16'sd1, -16'sd1, 16'sd1);

        run_phase(PHASE_ITEMS, 1'b0, 1'b0);

        // threshold zero, so any nonzero sum is a large change; no burst after it, nothing skipped
        configure('0, 0, 7, 0);
        run_phase(PHASE_ITEMS, 1'b0, 1'b1);

        // never a large change: only the skip limit forces reports
        configure(APB_DW'({THR_W{1'b1}}), 7, 0, 63);
        run_phase(PHASE_ITEMS, 1'b1, 1'b0);

        thr = APB_DW'($urandom_range(0, 32'h3fff_ffff));
        configure(thr, $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(1, 6));
        run_phase(PHASE_ITEMS, 1'b0, 1'b1);

        configure(APB_DW'(THR_RESET), 1, 1, 1);
        run_phase(PHASE_ITEMS, 1'b0, 1'b0);

        thr = {$urandom, $urandom};
        thr = thr >> $urandom_range(14, 50);
        configure(thr, $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 63));
        run_phase(PHASE_ITEMS, 1'b0, 1'b0);

        repeat (30) @(posedge clk);
        if (gate_sb.mismatches == 0 && gate_sb.pending() == 0)
            $display("** tilt_change_report_gate: PASSED **");
        else
            $display("** tilt_change_report_gate: FAILED **");
        $finish;
    end

endmodule
